### src/pvcd_pkg.sv
// Package: word types, command codes and register indexes for the valve command decoder.
`timescale 1ns / 1ps

package pvcd_pkg;

	localparam int unsigned VALVES = 5;

	// Input word kinds
	localparam logic KIND_CMD     = 1'b0;
	localparam logic KIND_PATTERN = 1'b1;

	// Command characters
	localparam logic [7:0] CMD_STOP      = 8'h21; // '!'
	localparam logic [7:0] CMD_INFLATE   = 8'h2B; // '+'
	localparam logic [7:0] CMD_VACUUM    = 8'h2D; // '-'
	localparam logic [7:0] CMD_INFLATE2X = 8'h50; // 'P'
	localparam logic [7:0] CMD_VACUUM2X  = 8'h4E; // 'N'
	localparam logic [7:0] CMD_RELEASE   = 8'h5E; // '^'
	localparam logic [7:0] CMD_POWER     = 8'h6F; // 'o'
	localparam logic [7:0] CMD_RED       = 8'h72; // 'r'
	localparam logic [7:0] CMD_BLUE      = 8'h62; // 'b'
	localparam logic [7:0] CMD_MEASURE   = 8'h3F; // '?'

	// Power-off only when the argument repeats the command character
	localparam logic [7:0] POWER_KEY = 8'h6F;

	// Pump level codes
	localparam logic [1:0] PUMP_OFF  = 2'd0;
	localparam logic [1:0] PUMP_ONE  = 2'd1;
	localparam logic [1:0] PUMP_TWO  = 2'd2;
	localparam logic [1:0] PUMP_BOTH = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_HAS_INFLATION = 2'd0;
	localparam logic [1:0] REG_HAS_VACUUM    = 2'd1;
	localparam logic [1:0] REG_PORTS_IN_USE  = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] action;
		logic [7:0] port;
	} in_word_t;

	typedef struct packed {
		logic                pump_one;
		logic                pump_two;
		logic                inlet_open;
		logic                release_open;
		logic [VALVES-1:0]   port_valves;
		logic                red_on;
		logic                blue_on;
		logic                power_off;
		logic                want_pressure;
	} out_word_t;

endpackage

### src/pneumatic_valve_command_decoder.sv
// Top level: pneumatic valve command decoder with input register, state and skid output.
`timescale 1ns / 1ps

// Accepts one command word per cycle while in_stall is low and returns one
// result word per command: the word is registered, decoded against the held
// pump, valve, LED and power-off levels in one pass, and the new levels land
// in the output register. A skid register behind the output lets the input
// keep flowing for one word while a result waits; in_stall rises only once
// that skid register is also full. Writes on the cfg port take effect for the
// next decoded word. PORTS limits which port numbers (1..PORTS, at most five)
// reach a valve.
module pneumatic_valve_command_decoder #(
	parameter int unsigned PORTS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [2:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  pvcd_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output pvcd_pkg::out_word_t out_word
);

	localparam int unsigned V   = pvcd_pkg::VALVES;
	localparam int unsigned LIM = (PORTS < V) ? PORTS : V;

	// configuration
	logic       has_inf_q;
	logic       has_vac_q;
	logic [2:0] ports_in_use_q;

	// held levels
	logic [1:0]   pump_q;
	logic         inlet_q;
	logic         release_q;
	logic [V-1:0] valves_q;
	logic [1:0]   led_q;
	logic         power_off_q;

	// input stage
	logic               valid_s1;
	pvcd_pkg::in_word_t word_s1;

	// output and skid
	logic                out_valid_q;
	pvcd_pkg::out_word_t out_q;
	logic                skid_valid_q;
	pvcd_pkg::out_word_t skid_q;

	logic in_take;
	logic adv;
	logic out_take;

	// next-state
	logic [1:0]   pump_d;
	logic         inlet_d;
	logic         release_d;
	logic [V-1:0] valves_d;
	logic [1:0]   led_d;
	logic         power_off_d;
	logic         want_d;
	logic [V-1:0] all_mask;
	logic [V-1:0] tgt_mask;
	logic [V-1:0] pattern;
	logic [2:0]   span;
	pvcd_pkg::out_word_t res;

	assign adv       = valid_s1 && !skid_valid_q;
	assign in_stall  = valid_s1 && skid_valid_q;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_inf_q      <= 1'b1;
			has_vac_q      <= 1'b1;
			ports_in_use_q <= 3'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pvcd_pkg::REG_HAS_INFLATION: has_inf_q      <= cfg_data[0];
				pvcd_pkg::REG_HAS_VACUUM:    has_vac_q      <= cfg_data[0];
				pvcd_pkg::REG_PORTS_IN_USE:  ports_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_word;
		end
	end

	// valve masks
	always_comb begin
		span = (ports_in_use_q > 3'(LIM)) ? 3'(LIM) : ports_in_use_q;
		for (int i = 0; i < V; i++) begin
			all_mask[i] = (3'(i) < span);
			pattern[i]  = word_s1.port[V-1-i];
			tgt_mask[i] = (word_s1.port == 8'(i + 1)) && (i < LIM);
		end
		if (word_s1.port == 8'd0) begin
			tgt_mask = all_mask;
		end
	end

	always_comb begin
		pump_d      = pump_q;
		inlet_d     = inlet_q;
		release_d   = release_q;
		valves_d    = valves_q;
		led_d       = led_q;
		power_off_d = power_off_q;
		want_d      = 1'b0;
		if (word_s1.kind == pvcd_pkg::KIND_PATTERN) begin
			valves_d = pattern;
		end else begin
			unique case (word_s1.action)
				pvcd_pkg::CMD_STOP,
				pvcd_pkg::CMD_INFLATE,
				pvcd_pkg::CMD_VACUUM,
				pvcd_pkg::CMD_INFLATE2X,
				pvcd_pkg::CMD_VACUUM2X,
				pvcd_pkg::CMD_RELEASE: begin
					// stop on the target ports first, then start the action
					inlet_d   = 1'b0;
					release_d = 1'b0;
					pump_d    = pvcd_pkg::PUMP_OFF;
					valves_d  = valves_q & ~tgt_mask;
					unique case (word_s1.action)
						pvcd_pkg::CMD_INFLATE: begin
							if (has_inf_q) begin
								inlet_d  = 1'b1;
								valves_d = valves_d | tgt_mask;
								pump_d   = pvcd_pkg::PUMP_ONE;
							end
							want_d = has_inf_q && has_vac_q;
						end
						pvcd_pkg::CMD_VACUUM: begin
							if (has_vac_q) begin
								valves_d  = valves_d | tgt_mask;
								pump_d    = pvcd_pkg::PUMP_TWO;
								release_d = has_inf_q;
							end
							want_d = has_inf_q && has_vac_q;
						end
						pvcd_pkg::CMD_INFLATE2X: begin
							if (has_inf_q && !has_vac_q) begin
								valves_d = valves_d | tgt_mask;
								pump_d   = pvcd_pkg::PUMP_BOTH;
							end
							want_d = has_inf_q && !has_vac_q;
						end
						pvcd_pkg::CMD_VACUUM2X: begin
							if (!has_inf_q && has_vac_q) begin
								valves_d = valves_d | tgt_mask;
								pump_d   = pvcd_pkg::PUMP_BOTH;
							end
							want_d = !has_inf_q && has_vac_q;
						end
						pvcd_pkg::CMD_RELEASE: begin
							release_d = 1'b1;
							valves_d  = valves_d | tgt_mask;
							want_d    = 1'b1;
						end
						default: ;
					endcase
				end
				pvcd_pkg::CMD_MEASURE: begin
					inlet_d   = 1'b0;
					release_d = 1'b0;
					pump_d    = pvcd_pkg::PUMP_OFF;
					valves_d  = (valves_q & ~all_mask) | tgt_mask;
					want_d    = 1'b1;
				end
				pvcd_pkg::CMD_POWER: begin
					if (word_s1.port == pvcd_pkg::POWER_KEY) begin
						power_off_d = 1'b1;
					end
				end
				pvcd_pkg::CMD_RED: begin
					led_d[0] = (word_s1.port != 8'd0);
				end
				pvcd_pkg::CMD_BLUE: begin
					led_d[1] = (word_s1.port != 8'd0);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.pump_one      = pump_d[0];
		res.pump_two      = pump_d[1];
		res.inlet_open    = inlet_d;
		res.release_open  = release_d;
		res.port_valves   = valves_d;
		res.red_on        = led_d[0];
		res.blue_on       = led_d[1];
		res.power_off     = power_off_d;
		res.want_pressure = want_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q      <= pvcd_pkg::PUMP_OFF;
			inlet_q     <= 1'b0;
			release_q   <= 1'b0;
			valves_q    <= '0;
			led_q       <= 2'b00;
			power_off_q <= 1'b0;
		end else if (adv) begin
			pump_q      <= pump_d;
			inlet_q     <= inlet_d;
			release_q   <= release_d;
			valves_q    <= valves_d;
			led_q       <= led_d;
			power_off_q <= power_off_d;
		end
	end

	// output word register with one-word skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= adv;
			end
		end else if (adv) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (adv) begin
				out_q <= res;
			end
		end else if (adv) begin
			skid_q <= res;
		end
	end

endmodule

### bench/tb.sv
// Testbench for the pneumatic valve command decoder: random and directed words, scoreboard checks.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned PORTS = 5;

	// Tracks valve controller levels and the queue of result words still due.
	class valve_scoreboard;
		bit       has_inf;
		bit       has_vac;
		bit [2:0] span_cfg;
		bit [1:0] pumps;
		bit       inlet;
		bit       vent;
		bit [4:0] valves;
		bit [1:0] leds;
		bit       latch;
		pvcd_pkg::out_word_t levels_due[$];
		int errors;
		int checked;
		int patterns;
		int pressure_reqs;

		function new();
			has_inf = 1;
			has_vac = 1;
			span_cfg = 5;
			pumps = pvcd_pkg::PUMP_OFF;
			inlet = 0;
			vent = 0;
			valves = '0;
			leds = '0;
			latch = 0;
		endfunction

		function void set_cfg(bit inf, bit vac, bit [2:0] n);
			has_inf = inf;
			has_vac = vac;
			span_cfg = n;
		endfunction

		function int pending();
			return levels_due.size();
		endfunction

		// ports 1..n, n saturated at PORTS and at the valve count
		function bit [4:0] span_mask();
			int unsigned n;
			n = span_cfg;
			if (n > PORTS) n = PORTS;
			if (n > pvcd_pkg::VALVES) n = pvcd_pkg::VALVES;
			return 5'((32'd1 << n) - 1);
		endfunction

		function bit [4:0] port_bit(bit [7:0] p);
			if (p == 0 || p > PORTS || p > pvcd_pkg::VALVES) return '0;
			return 5'(32'd1 << (p - 1));
		endfunction

		function void halt(bit [4:0] m);
			inlet = 0;
			vent = 0;
			valves &= ~m;
			pumps = pvcd_pkg::PUMP_OFF;
		endfunction

		function void note_input(pvcd_pkg::in_word_t w);
			pvcd_pkg::out_word_t e;
			bit [4:0] m;
			bit want;
			m = (w.port == 0) ? span_mask() : port_bit(w.port);
			want = 0;
			if (w.kind == pvcd_pkg::KIND_PATTERN) begin
				// bit4 of the pattern is port one
				for (int i = 0; i < 5; i++) valves[i] = w.port[4 - i];
				patterns++;
			end else begin
				case (w.action)
					pvcd_pkg::CMD_STOP: halt(m);
					pvcd_pkg::CMD_INFLATE: begin
						halt(m);
						if (has_inf) begin
							inlet = 1;
							valves |= m;
							pumps = pvcd_pkg::PUMP_ONE;
						end
						want = has_inf && has_vac;
					end
					pvcd_pkg::CMD_VACUUM: begin
						halt(m);
						if (has_vac) begin
							valves |= m;
							pumps = pvcd_pkg::PUMP_TWO;
							if (has_inf) vent = 1;
						end
						want = has_inf && has_vac;
					end
					pvcd_pkg::CMD_INFLATE2X: begin
						halt(m);
						want = has_inf && !has_vac;
						if (want) begin
							valves |= m;
							pumps = pvcd_pkg::PUMP_BOTH;
						end
					end
					pvcd_pkg::CMD_VACUUM2X: begin
						halt(m);
						want = !has_inf && has_vac;
						if (want) begin
							valves |= m;
							pumps = pvcd_pkg::PUMP_BOTH;
						end
					end
					pvcd_pkg::CMD_RELEASE: begin
						halt(m);
						vent = 1;
						valves |= m;
						want = 1;
					end
					pvcd_pkg::CMD_POWER: if (w.port == pvcd_pkg::POWER_KEY) latch = 1;
					pvcd_pkg::CMD_RED: leds[0] = (w.port != 0);
					pvcd_pkg::CMD_BLUE: leds[1] = (w.port != 0);
					pvcd_pkg::CMD_MEASURE: begin
						halt(span_mask());
						valves |= m;
						want = 1;
					end
					default: ;
				endcase
			end
			pressure_reqs += want;
			e.pump_one = pumps[0];
			e.pump_two = pumps[1];
			e.inlet_open = inlet;
			e.release_open = vent;
			e.port_valves = valves;
			e.red_on = leds[0];
			e.blue_on = leds[1];
			e.power_off = latch;
			e.want_pressure = want;
			levels_due.push_back(e);
		endfunction

		function int cmp(string name, logic [7:0] exp, logic [7:0] act);
			if (act === exp) return 0;
			$error("%s: expected %0h, got %0h", name, exp, act);
			return 1;
		endfunction

		function void check_result(pvcd_pkg::out_word_t got);
			pvcd_pkg::out_word_t e;
			if (levels_due.size() == 0) begin
				$error("result word with nothing outstanding: %h", got);
				errors++;
				return;
			end
			e = levels_due.pop_front();
			checked++;
			errors += cmp("pump_one", 8'(e.pump_one), 8'(got.pump_one));
			errors += cmp("pump_two", 8'(e.pump_two), 8'(got.pump_two));
			errors += cmp("inlet_open", 8'(e.inlet_open), 8'(got.inlet_open));
			errors += cmp("release_open", 8'(e.release_open), 8'(got.release_open));
			errors += cmp("port_valves", 8'(e.port_valves), 8'(got.port_valves));
			errors += cmp("red_on", 8'(e.red_on), 8'(got.red_on));
			errors += cmp("blue_on", 8'(e.blue_on), 8'(got.blue_on));
			errors += cmp("power_off", 8'(e.power_off), 8'(got.power_off));
			errors += cmp("want_pressure", 8'(e.want_pressure), 8'(got.want_pressure));
		endfunction
	endclass

	logic      clk = 0;
	logic      arst_n;
	logic      cfg_we;
	logic [1:0] cfg_index;
	logic [2:0] cfg_data;
	logic      in_valid;
	logic      in_stall;
	pvcd_pkg::in_word_t  in_word;
	logic      out_valid;
	logic      out_stall;
	pvcd_pkg::out_word_t out_word;

	logic hold_req;
	int   idle_pct;
	int   stall_pct;
	int   hold_cycles;
	valve_scoreboard sb;

	pneumatic_valve_command_decoder #(.PORTS(PORTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_input(in_word);
			if (out_valid && !out_stall) sb.check_result(out_word);
		end
	end

	// result side: random stalls, or a long counted hold when asked
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = 80;
				hold_cycles += 80;
				hold_req <= 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		#1000000;
		$display("** pneumatic_valve_command_decoder: FAILED **");
		$finish;
	end

	task automatic send(pvcd_pkg::in_word_t w);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic cmd(logic [7:0] action, logic [7:0] port);
		send('{pvcd_pkg::KIND_CMD, action, port});
	endtask

	task automatic drain();
		in_valid <= 0;
		// let the last accepted word reach the scoreboard first
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(bit inf, bit vac, bit [2:0] n);
		drain();
		cfg_we <= 1;
		cfg_index <= pvcd_pkg::REG_HAS_INFLATION;
		cfg_data <= {2'b00, inf};
		@(posedge clk);
		cfg_index <= pvcd_pkg::REG_HAS_VACUUM;
		cfg_data <= {2'b00, vac};
		@(posedge clk);
		cfg_index <= pvcd_pkg::REG_PORTS_IN_USE;
		cfg_data <= n;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_cfg(inf, vac, n);
	endtask

	// mostly proper commands with small port numbers; some patterns and noise
	function automatic pvcd_pkg::in_word_t make_word(bit allow_power);
		logic [7:0] codes[10];
		pvcd_pkg::in_word_t w;
		int r;
		codes = '{pvcd_pkg::CMD_STOP, pvcd_pkg::CMD_INFLATE, pvcd_pkg::CMD_VACUUM,
			pvcd_pkg::CMD_INFLATE2X, pvcd_pkg::CMD_VACUUM2X, pvcd_pkg::CMD_RELEASE,
			pvcd_pkg::CMD_POWER, pvcd_pkg::CMD_RED, pvcd_pkg::CMD_BLUE,
			pvcd_pkg::CMD_MEASURE};
		r = $urandom_range(99);
		w.kind = pvcd_pkg::KIND_CMD;
		w.action = 8'($urandom);
		w.port = 8'($urandom);
		if (r < 12) begin
			w.kind = pvcd_pkg::KIND_PATTERN;
		end else if (r >= 20) begin
			w.action = codes[$urandom_range(9)];
			if ($urandom_range(3) != 0) w.port = 8'($urandom_range(7));
			if (w.action == pvcd_pkg::CMD_POWER && allow_power && $urandom_range(3) == 0)
				w.port = pvcd_pkg::POWER_KEY;
		end
		// keep the power-off latch clear until the last phase
		if (!allow_power && w.kind == pvcd_pkg::KIND_CMD && w.action == pvcd_pkg::CMD_POWER
				&& w.port == pvcd_pkg::POWER_KEY)
			w.port = 8'h00;
		return w;
	endfunction

	initial begin
		bit       inf_set[8];
		bit       vac_set[8];
		bit [2:0] span_set[8];
		inf_set = '{1, 0, 1, 0, 1, 0, 1, 1};
		vac_set = '{1, 1, 0, 0, 1, 1, 0, 1};
		span_set = '{5, 0, 3, 7, 1, 6, 4, 2};
		arst_n = 0;
		cfg_we = 0;
		cfg_index = pvcd_pkg::REG_HAS_INFLATION;
		cfg_data = '0;
		in_valid = 0;
		in_word = '0;
		hold_req = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		configure(1, 1, 5);
		send('{pvcd_pkg::KIND_PATTERN, 8'h00, 8'h00});
		send('{pvcd_pkg::KIND_PATTERN, 8'hFF, 8'hFF});
		send('{pvcd_pkg::KIND_PATTERN, 8'h2B, 8'h10});
		send('{pvcd_pkg::KIND_PATTERN, 8'h00, 8'hE1});
		cmd(pvcd_pkg::CMD_INFLATE, 8'd0);
		cmd(pvcd_pkg::CMD_STOP, 8'd3);
		cmd(pvcd_pkg::CMD_VACUUM, 8'd1);
		cmd(pvcd_pkg::CMD_RELEASE, 8'd5);
		cmd(pvcd_pkg::CMD_MEASURE, 8'd2);
		cmd(pvcd_pkg::CMD_MEASURE, 8'd0);
		cmd(pvcd_pkg::CMD_INFLATE2X, 8'd0);
		cmd(pvcd_pkg::CMD_VACUUM2X, 8'd4);
		cmd(pvcd_pkg::CMD_INFLATE, 8'd6);   // no such port
		cmd(pvcd_pkg::CMD_VACUUM, 8'd255);
		cmd(pvcd_pkg::CMD_RED, 8'd1);
		cmd(pvcd_pkg::CMD_RED, 8'd0);
		cmd(pvcd_pkg::CMD_BLUE, 8'd200);
		cmd(pvcd_pkg::CMD_BLUE, 8'd0);
		cmd(pvcd_pkg::CMD_POWER, 8'd0);
		cmd(pvcd_pkg::CMD_POWER, 8'h4F);    // wrong key, latch stays clear
		cmd(8'h00, 8'h00);
		cmd(8'hFF, 8'hFF);
		configure(1, 0, 2);
		cmd(pvcd_pkg::CMD_INFLATE2X, 8'd0);
		cmd(pvcd_pkg::CMD_VACUUM, 8'd1);
		configure(0, 1, 7);
		cmd(pvcd_pkg::CMD_VACUUM2X, 8'd0);
		cmd(pvcd_pkg::CMD_MEASURE, 8'd0);

		for (int ph = 0; ph < 8; ph++) begin
			configure(inf_set[ph], vac_set[ph], span_set[ph]);
			idle_pct = (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 36 : 0;
			stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 36 : 0;
			// output held off while words keep coming, to back the block up
			if (ph == 0) hold_req <= 1;
			for (int k = 0; k < 200; k++) begin
				if (ph == 5 && k == 100) drain();
				send(make_word(ph == 7));
			end
		end

		drain();
		$display("Checked %0d result words: %0d port patterns, %0d pressure requests,",
			sb.checked, sb.patterns, sb.pressure_reqs);
		$display("eleven register settings, four idle mixes and a %0d-cycle output hold.",
			hold_cycles);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** pneumatic_valve_command_decoder: PASSED **");
		end else begin
			$display("** pneumatic_valve_command_decoder: FAILED **");
		end
		$finish;
	end

endmodule
